### sv/sds_pkg.sv
// sds_pkg: shared widths, register indexes and the queue item type
// used by the front, queue and back of the substring delete stream
package sds_pkg;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int QDEPTH    = 2;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'b1;

  typedef enum logic {
    K_MATCH,
    K_PASS
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    kind_t             kind;
  } item_t;

endpackage

### sv/sds_if.sv
// sds_if: valid/ready channel interfaces for input bytes and results
// depends on sds_pkg for field widths
interface sds_in_if;
  logic                      valid;
  logic                      ready;
  logic [sds_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface sds_out_if;
  logic                      valid;
  logic                      ready;
  logic [sds_pkg::BYTE_W-1:0] out_byte;
  logic                      has_byte;
  logic                      out_last;

  modport source (output valid, out_byte, has_byte, out_last, input ready);
  modport sink   (input valid, out_byte, has_byte, out_last, output ready);
endinterface

### sv/sds_front.sv
// sds_front: accepts input bytes, clamps the pattern length and tags
// each item as pass-through or match work; depends on sds_pkg, sds_if
module sds_front #(
  parameter int MAX_PATTERN = 8
) (
  sds_in_if.sink                     in_ch,
  input  logic [sds_pkg::LEN_W-1:0]  cfg_len,
  input  logic                       q_full,
  output logic                       q_wr,
  output sds_pkg::item_t             q_item,
  output logic [sds_pkg::LEN_W-1:0]  eff_len
);
  import sds_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  assign eff_len     = (cfg_len > MAX_LEN) ? MAX_LEN : cfg_len;
  assign in_ch.ready = !q_full;
  assign q_wr        = in_ch.valid && !q_full;

  always_comb begin
    q_item.data = in_ch.in_byte;
    q_item.last = in_ch.in_last;
    q_item.kind = (eff_len == '0) ? K_PASS : K_MATCH;
  end

endmodule

### sv/sds_queue.sv
// sds_queue: short item queue between front and back
// depends on sds_pkg for the item type and depth
module sds_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  sds_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd,
  output logic           rd_valid,
  output sds_pkg::item_t rd_item
);
  import sds_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

endmodule

### sv/sds_back.sv
// sds_back: pending byte store, prefix check and results into the output register,
// which holds under back-pressure; an item is popped only once it is done; depends on sds_pkg and sds_if
module sds_back #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sds_pkg::PAT_W-1:0] pattern,
  input  logic [sds_pkg::LEN_W-1:0] eff_len,
  input  logic                      q_valid,
  input  sds_pkg::item_t            q_item,
  output logic                      q_pop,
  sds_out_if.source                 out_ch
);
  import sds_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PATTERN);

  typedef enum logic [1:0] {
    PH_PUSH,
    PH_SCAN,
    PH_FLUSH
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] store_r [MAX_PATTERN];
  logic [BYTE_W-1:0] store_nxt [MAX_PATTERN];
  logic              emitted_r, emitted_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              ohas_r, ohas_nxt;
  logic              olast_r, olast_nxt;

  logic [BYTE_W-1:0] pat_b [MAX_PATTERN];
  logic [BYTE_W-1:0] shifted [MAX_PATTERN];
  logic              ok_cur, ok_nxt, prefix_cur, prefix_nxt;
  logic [CNT_W-1:0]  cnt_dec;
  logic              out_free;

  assign cnt_dec  = cnt_r - 1'b1;
  assign out_free = !ovalid_r || out_ch.ready;

  // prefix test of the store now and after dropping its oldest byte
  always_comb begin
    ok_cur = 1'b1;
    ok_nxt = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_b[i]   = pattern[BYTE_W*i +: BYTE_W];
      shifted[i] = '0;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CNT_W'(i) < cnt_r && store_r[i] != pat_b[i]) begin
        ok_cur = 1'b0;
      end
    end
    for (int i = 1; i < MAX_PATTERN; i++) begin
      shifted[i-1] = store_r[i];
      if (CNT_W'(i) < cnt_r && store_r[i] != pat_b[i-1]) begin
        ok_nxt = 1'b0;
      end
    end
    prefix_cur = ok_cur && (LEN_W'(cnt_r) <= eff_len);
    prefix_nxt = ok_nxt && (LEN_W'(cnt_dec) <= eff_len);
  end

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    store_nxt   = store_r;
    emitted_nxt = emitted_r;
    ovalid_nxt  = ovalid_r && !out_ch.ready;
    obyte_nxt   = obyte_r;
    ohas_nxt    = ohas_r;
    olast_nxt   = olast_r;
    q_pop       = 1'b0;

    case (phase_r)
      PH_PUSH: begin
        if (q_valid) begin
          if (q_item.kind == K_PASS) begin
            if (out_free) begin
              ovalid_nxt = 1'b1;
              ohas_nxt   = 1'b1;
              if (cnt_r != '0) begin
                // drain what an earlier pattern left behind
                obyte_nxt   = store_r[0];
                olast_nxt   = 1'b0;
                store_nxt   = shifted;
                cnt_nxt     = cnt_dec;
                emitted_nxt = 1'b1;
              end else begin
                obyte_nxt   = q_item.data;
                olast_nxt   = q_item.last;
                q_pop       = 1'b1;
                emitted_nxt = 1'b0;
              end
            end
          end else if (cnt_r == FULL_CNT) begin
            if (out_free) begin
              ovalid_nxt  = 1'b1;
              ohas_nxt    = 1'b1;
              obyte_nxt   = store_r[0];
              olast_nxt   = 1'b0;
              store_nxt   = shifted;
              cnt_nxt     = cnt_dec;
              emitted_nxt = 1'b1;
            end
          end else begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
              if (cnt_r == CNT_W'(i)) begin
                store_nxt[i] = q_item.data;
              end
            end
            cnt_nxt   = cnt_r + 1'b1;
            phase_nxt = PH_SCAN;
          end
        end
      end
      PH_SCAN: begin
        if (cnt_r == '0 || (prefix_cur && !q_item.last)) begin
          if (prefix_cur && LEN_W'(cnt_r) == eff_len) begin
            cnt_nxt = '0;
          end
          q_pop       = 1'b1;
          emitted_nxt = 1'b0;
          phase_nxt   = PH_PUSH;
        end else if (prefix_cur && LEN_W'(cnt_r) != eff_len) begin
          phase_nxt = PH_FLUSH;
        end else if (prefix_cur) begin
          // last item ends on a full match: close with a bare marker if needed
          if (emitted_r || out_free) begin
            cnt_nxt     = '0;
            q_pop       = 1'b1;
            emitted_nxt = 1'b0;
            phase_nxt   = PH_PUSH;
            if (!emitted_r) begin
              ovalid_nxt = 1'b1;
              ohas_nxt   = 1'b0;
              obyte_nxt  = '0;
              olast_nxt  = 1'b1;
            end
          end
        end else if (out_free) begin
          ovalid_nxt  = 1'b1;
          ohas_nxt    = 1'b1;
          obyte_nxt   = store_r[0];
          // final result when nothing else can come out of this item
          olast_nxt   = q_item.last && (cnt_dec == '0 ||
                        (prefix_nxt && LEN_W'(cnt_dec) == eff_len));
          store_nxt   = shifted;
          cnt_nxt     = cnt_dec;
          emitted_nxt = 1'b1;
        end
      end
      PH_FLUSH: begin
        if (out_free) begin
          ovalid_nxt  = 1'b1;
          ohas_nxt    = 1'b1;
          obyte_nxt   = store_r[0];
          olast_nxt   = (cnt_dec == '0);
          store_nxt   = shifted;
          cnt_nxt     = cnt_dec;
          emitted_nxt = 1'b1;
          if (cnt_dec == '0) begin
            q_pop       = 1'b1;
            emitted_nxt = 1'b0;
            phase_nxt   = PH_PUSH;
          end
        end
      end
      default: begin
        phase_nxt = PH_PUSH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PUSH;
      cnt_r     <= '0;
      emitted_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      emitted_r <= emitted_nxt;
      ovalid_r  <= ovalid_nxt;
    end
    store_r <= store_nxt;
    obyte_r <= obyte_nxt;
    ohas_r  <= ohas_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid    = ovalid_r;
  assign out_ch.out_byte = obyte_r;
  assign out_ch.has_byte = ohas_r;
  assign out_ch.out_last = olast_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("pending count above store depth");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FLUSH |-> cnt_r != '0)
    else $error("flush with empty store");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop without item");

  a_push_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PUSH && q_valid && q_item.kind == K_MATCH && cnt_r != FULL_CNT)
    |=> phase_r == PH_SCAN)
    else $error("pushed byte not scanned");

endmodule

### sv/substring_delete_stream.sv
// substring_delete_stream: deletes every occurrence of a pattern from a byte string
// path: with length zero an accepted byte goes through the queue into the output
//   register; otherwise it passes a store push and a prefix check first
// flow: pass-through (length zero) one item per cycle while the output is free;
//   otherwise each item takes a store push and a prefix check, and pending bytes are
//   emitted one at a time by the single store and output register of the back end
// reset: synchronous active low; clears the queue, pending count, output valid and both config registers
module substring_delete_stream #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sds_in_if.sink                        in_ch,
  sds_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sds_pkg::PAT_W-1:0]     cfg_data
);
  import sds_pkg::*;

  logic [PAT_W-1:0] pattern_r, pattern_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [LEN_W-1:0] eff_len;
  logic             q_wr, q_full, q_pop, q_valid;
  item_t            wr_item, rd_item;

  always_comb begin
    pattern_nxt = pattern_r;
    plen_nxt    = plen_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN: pattern_nxt = cfg_data;
        REG_LENGTH:  plen_nxt    = cfg_data[LEN_W-1:0];
        default: begin
          pattern_nxt = pattern_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= '0;
    end else begin
      pattern_r <= pattern_nxt;
      plen_r    <= plen_nxt;
    end
  end

  sds_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
    .in_ch   (in_ch),
    .cfg_len (plen_r),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_item  (wr_item),
    .eff_len (eff_len)
  );

  sds_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_item  (wr_item),
    .full     (q_full),
    .rd       (q_pop),
    .rd_valid (q_valid),
    .rd_item  (rd_item)
  );

  sds_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .pattern (pattern_r),
    .eff_len (eff_len),
    .q_valid (q_valid),
    .q_item  (rd_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for substring_delete_stream, drives bytes and
// pattern settings and checks every result against an in-bench deletion model or a typed expected value
// depends on sds_pkg and the sds_in_if / sds_out_if interfaces
module testbench;
  import sds_pkg::*;

  localparam int HELD_MAX      = 8;
  localparam int RANDOM_ITEMS  = 420;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 2000;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TYPED,
    ROW_PATTERN,
    ROW_LENGTH
  } row_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              eos;
  } result_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [PAT_W-1:0]  val;
    logic              eos;
    result_t           want;
  } stim_row_t;

  localparam result_t NO_WANT = '0;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_data;

  sds_in_if  in_ch ();
  sds_out_if out_ch ();

  substring_delete_stream #(.MAX_PATTERN(HELD_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // deletion model state
  logic [PAT_W-1:0]  pat_reg = '0;
  logic [LEN_W-1:0]  len_reg = '0;
  logic [BYTE_W-1:0] held_bytes [HELD_MAX] = '{default: 8'h00};
  int                held_cnt = 0;

  result_t step_out[$];
  result_t survivors_q[$];
  result_t head_want;
  int      mismatches = 0;
  int      burst_left = 1;
  int      quiet_cycles = 0;
  int      rdy_mode = 0;
  int      rdy_left = 0;

  stim_row_t directed_rows [32] = '{
    // pass-through after reset
    '{ROW_TYPED,   64'h00,     1'b0, '{8'h00, 1'b1, 1'b0}},
    '{ROW_TYPED,   64'hFF,     1'b1, '{8'hFF, 1'b1, 1'b1}},
    // pattern "abc"
    '{ROW_PATTERN, 64'h636261, 1'b0, NO_WANT},
    '{ROW_LENGTH,  64'h3,      1'b0, NO_WANT},
    '{ROW_BYTE,    64'h61,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h62,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h63,     1'b0, NO_WANT},
    '{ROW_TYPED,   64'h78,     1'b1, '{8'h78, 1'b1, 1'b1}},
    // whole string deleted: bare end marker
    '{ROW_BYTE,    64'h61,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h62,     1'b0, NO_WANT},
    '{ROW_TYPED,   64'h63,     1'b1, '{8'h00, 1'b0, 1'b1}},
    // broken prefix, then a match, then a held byte flushed at the end
    '{ROW_BYTE,    64'h61,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h62,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h61,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h62,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h63,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h61,     1'b1, NO_WANT},
    // longest pattern, seven held bytes all released by one mismatch
    '{ROW_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
    '{ROW_LENGTH,  64'h8,      1'b0, NO_WANT},
    '{ROW_BYTE,    64'hFF,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'hFF,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'hFF,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'hFF,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'hFF,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'hFF,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'hFF,     1'b0, NO_WANT},
    '{ROW_BYTE,    64'h00,     1'b1, NO_WANT},
    // length above the maximum, then pattern disabled while a byte is held
    '{ROW_PATTERN, 64'h0,      1'b0, NO_WANT},
    '{ROW_LENGTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
    '{ROW_BYTE,    64'h00,     1'b0, NO_WANT},
    '{ROW_LENGTH,  64'h0,      1'b0, NO_WANT},
    '{ROW_BYTE,    64'h41,     1'b1, NO_WANT}
  };

  function automatic bit held_is_prefix(int len);
    if (held_cnt > len) return 1'b0;
    for (int i = 0; i < held_cnt; i++)
      if (held_bytes[i] != pat_reg[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] pop_held();
    logic [BYTE_W-1:0] b;
    b = held_bytes[0];
    for (int i = 0; i < HELD_MAX - 1; i++) held_bytes[i] = held_bytes[i+1];
    held_bytes[HELD_MAX-1] = 8'h00;
    held_cnt--;
    return b;
  endfunction

  // results caused by one accepted byte, left in step_out
  function automatic void strip_step(logic [BYTE_W-1:0] b, logic eos);
    int len;
    len = (len_reg > HELD_MAX) ? HELD_MAX : int'(len_reg);
    step_out.delete();
    if (len == 0) begin
      while (held_cnt > 0) step_out.push_back('{pop_held(), 1'b1, 1'b0});
      step_out.push_back('{b, 1'b1, 1'b0});
    end else begin
      if (held_cnt >= HELD_MAX) step_out.push_back('{pop_held(), 1'b1, 1'b0});
      held_bytes[held_cnt] = b;
      held_cnt++;
      while (held_cnt > 0) begin
        if (held_is_prefix(len)) begin
          if (held_cnt == len) begin
            held_bytes = '{default: 8'h00};
            held_cnt = 0;
          end
          break;
        end
        step_out.push_back('{pop_held(), 1'b1, 1'b0});
      end
    end
    if (eos) begin
      while (held_cnt > 0) step_out.push_back('{pop_held(), 1'b1, 1'b0});
      if (step_out.size() > 0) step_out[step_out.size()-1].eos = 1'b1;
      else step_out.push_back('{8'h00, 1'b0, 1'b1});
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eos, input bit typed,
                           input result_t want);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= eos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    strip_step(b, eos);
    if (typed) survivors_q.push_back(want);
    else foreach (step_out[i]) survivors_q.push_back(step_out[i]);
    burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  // wait until every result is out and held bytes have settled
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (survivors_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] word);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PATTERN) pat_reg = word;
    else len_reg = word[LEN_W-1:0];
  endtask

  // receiver: ready follows a randomly picked mode that is picked anew whenever its countdown runs out
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(20, 200);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((rdy_left % 32) < 6);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (survivors_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h has=%b last=%b",
                                  out_ch.out_byte, out_ch.has_byte, out_ch.out_last));
      end else begin
        head_want = survivors_q.pop_front();
        if (out_ch.out_byte !== head_want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte, head_want.data));
        if (out_ch.has_byte !== head_want.has)
          report_mismatch($sformatf("has_byte %b, want %b", out_ch.has_byte, head_want.has));
        if (out_ch.out_last !== head_want.eos)
          report_mismatch($sformatf("out_last %b, want %b", out_ch.out_last, head_want.eos));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int                random_items;
    int                pick;
    int                k;
    int                plen;
    int                elen;
    int                phase_items;
    int                sent;
    logic [PAT_W-1:0]  pat;
    logic [PAT_W-1:0]  len_word;
    logic [BYTE_W-1:0] chunk[$];

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    random_items  = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_PATTERN: write_reg(REG_PATTERN, directed_rows[r].val);
        ROW_LENGTH:  write_reg(REG_LENGTH, directed_rows[r].val);
        ROW_TYPED: begin
          send_item(directed_rows[r].val[7:0], directed_rows[r].eos, 1'b1,
                    directed_rows[r].want);
        end
        default: begin
          send_item(directed_rows[r].val[7:0], directed_rows[r].eos, 1'b0, NO_WANT);
        end
      endcase
    end

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: plen = 0;
        1: plen = $urandom_range(9, 15);
        2: plen = 8;
        default: plen = $urandom_range(1, 7);
      endcase
      elen = (plen > HELD_MAX) ? HELD_MAX : plen;
      pat = {$urandom, $urandom};
      // a small alphabet gives self-overlapping patterns and frequent partial matches
      if ($urandom_range(0, 1) == 1)
        for (int i = 0; i < 8; i++) pat[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = plen[LEN_W-1:0];
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_PATTERN, pat);
        write_reg(REG_LENGTH, len_word);
      end else begin
        write_reg(REG_LENGTH, len_word);
        write_reg(REG_PATTERN, pat);
      end

      phase_items = $urandom_range(20, 60);
      sent = 0;
      while (sent < phase_items) begin
        chunk.delete();
        pick = $urandom_range(0, 9);
        if (elen > 0 && pick < 4) begin
          for (int i = 0; i < elen; i++) chunk.push_back(pat[8*i +: 8]);
        end else if (elen > 1 && pick < 6) begin
          // a prefix that may be broken by one more byte
          k = $urandom_range(1, elen - 1);
          for (int i = 0; i < k; i++) chunk.push_back(pat[8*i +: 8]);
          if ($urandom_range(0, 1) == 1) chunk.push_back(pat[8*$urandom_range(0, 7) +: 8]);
        end else if (pick < 8) begin
          k = $urandom_range(0, 7);
          chunk.push_back(pat[8*k +: 8]);
        end else begin
          chunk.push_back(8'($urandom_range(0, 255)));
        end
        foreach (chunk[i]) begin
          send_item(chunk[i], ($urandom_range(0, 7) == 0), 1'b0, NO_WANT);
          sent++;
          random_items++;
        end
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sds_pkg.sv
sv/sds_if.sv
sv/sds_front.sv
sv/sds_queue.sv
sv/sds_back.sv
sv/substring_delete_stream.sv
tb/sv/testbench.sv
